### sv/assert_macros.svh
// Assertion helpers for the terminal engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/ttce_pkg.sv
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared constants and types of the character terminal engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ttce_pkg;
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_TAB_WIDTH   = 8;

   localparam logic [1:0] ACT_PUT  = 2'd0;
   localparam logic [1:0] ACT_AT   = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [2:0] REG_COLS     = 3'd0;
   localparam logic [2:0] REG_ROWS     = 3'd1;
   localparam logic [2:0] REG_TEXT_FG  = 3'd2;
   localparam logic [2:0] REG_TEXT_BG  = 3'd3;
   localparam logic [2:0] REG_BLANK_FG = 3'd4;
   localparam logic [2:0] REG_BLANK_BG = 3'd5;
   localparam logic [2:0] REG_ENABLED  = 3'd6;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_HOME = 8'h48;
   localparam logic [23:0] DEFAULT_FG = 24'hCCCCCC;

   typedef logic [55:0] cell_type;
endpackage
`default_nettype wire

### sv/text_terminal_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_top: character-cell terminal engine on one screen store
// Handshake: one word in flight, and a pending result blocks new input
// Reset: synchronous; a clearing pass writes every store cell before the first accept
// ----------------------------------------------------------------------------
`default_nettype none
module text_terminal_cursor_engine_top #(
   parameter int MAX_COLUMNS = ttce_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ttce_pkg::DEF_MAX_ROWS,
   parameter int TAB_WIDTH   = ttce_pkg::DEF_TAB_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [6:0]  req_pos_x,
   input  wire logic [5:0]  req_pos_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_cell_char,
   output logic [23:0]      rsp_cell_fg,
   output logic [23:0]      rsp_cell_bg,
   output logic [6:0]       rsp_cursor_col,
   output logic [5:0]       rsp_cursor_row,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   import ttce_pkg::*;
   `include "assert_macros.svh"

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int AW = CW + RW;
   localparam int CCW = $clog2(MAX_COLUMNS + 1);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int TW = $clog2(TAB_WIDTH + 1);
   localparam int TAB_MUL = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_EXEC  = 4'd2;
   localparam logic [3:0] ST_TAB   = 4'd4;
   localparam logic [3:0] ST_SCRD  = 4'd5;
   localparam logic [3:0] ST_SCWR  = 4'd6;
   localparam logic [3:0] ST_SCBL  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // Configuration registers
   logic [7:0]  cols_reg_ff;
   logic [6:0]  rows_reg_ff;
   logic [23:0] text_fg_ff, text_bg_ff, blank_fg_ff, blank_bg_ff;
   logic        enabled_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_reg_ff <= 8'd80;
         rows_reg_ff <= 7'd25;
         text_fg_ff  <= DEFAULT_FG;
         text_bg_ff  <= '0;
         blank_fg_ff <= DEFAULT_FG;
         blank_bg_ff <= '0;
         enabled_ff  <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_COLS:     cols_reg_ff <= csr_data[7:0];
            REG_ROWS:     rows_reg_ff <= csr_data[6:0];
            REG_TEXT_FG:  text_fg_ff  <= csr_data;
            REG_TEXT_BG:  text_bg_ff  <= csr_data;
            REG_BLANK_FG: blank_fg_ff <= csr_data;
            REG_BLANK_BG: blank_bg_ff <= csr_data;
            REG_ENABLED:  enabled_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp screen size to 1..MAX
   logic [CCW-1:0] cols;
   logic [RCW-1:0] rows;
   always_comb begin
      if (cols_reg_ff == 8'd0) cols = CCW'(1);
      else if (32'(cols_reg_ff) > MAX_COLUMNS) cols = CCW'(MAX_COLUMNS);
      else cols = CCW'(cols_reg_ff);
      if (rows_reg_ff == 7'd0) rows = RCW'(1);
      else if (32'(rows_reg_ff) > MAX_ROWS) rows = RCW'(MAX_ROWS);
      else rows = RCW'(rows_reg_ff);
   end
   logic [CW-1:0] last_col;
   logic [RW-1:0] last_row;
   assign last_col = CW'(cols - CCW'(1));
   assign last_row = RW'(rows - RCW'(1));

   // Control state
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [CW-1:0] cx_ff, cx_in, wx_ff, wx_in, sx_ff, sx_in;
   logic [RW-1:0] cy_ff, cy_in, wy_ff, wy_in, sy_ff, sy_in;
   logic [1:0]    esc_ff, esc_in;
   logic [1:0]    act_ff, act_in;
   logic [7:0]    ch_ff, ch_in;
   logic          inside_ff, inside_in;
   logic [TW-1:0] tab_ff, tab_in;
   logic [CW-1:0] scx_ff, scx_in;
   logic [RW-1:0] scy_ff, scy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [55:0]   rsp_cell_ff, rsp_cell_in;
   logic [CW-1:0] rsp_col_ff, rsp_col_in;
   logic [RW-1:0] rsp_row_ff, rsp_row_in;

   // Store port signals
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   cell_type      wr_data, rd_data;

   ttce_store #(.AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   logic accept;
   assign accept = req_valid && !req_stall;

   // Request fields at acceptance
   logic in_inside;
   assign in_inside = (32'(req_pos_x) < 32'(cols)) && (32'(req_pos_y) < 32'(rows));

   // Advance helper on the working position
   logic          adv_wrap, adv_scroll;
   assign adv_wrap   = (wx_ff >= last_col);
   assign adv_scroll = (wy_ff >= last_row);

   // Tab distance: TAB_WIDTH - ((column + 1) mod TAB_WIDTH), remainder by reciprocal multiply
   logic [8:0]    tab_pos, tab_quo, tab_rem;
   logic [24:0]   tab_prod;
   logic [TW-1:0] tab_step;
   assign tab_pos  = 9'(wx_ff) + 9'd1;
   assign tab_prod = 25'(tab_pos) * 25'(TAB_MUL);
   assign tab_quo  = tab_prod[24:16];
   assign tab_rem  = tab_pos - 9'(tab_quo * 9'(TAB_WIDTH));
   assign tab_step = TW'(TAB_WIDTH) - TW'(tab_rem);

   always_comb begin
      state_in = state_ff; sweep_in = sweep_ff;
      cx_in = cx_ff; cy_in = cy_ff; wx_in = wx_ff; wy_in = wy_ff;
      sx_in = sx_ff; sy_in = sy_ff; esc_in = esc_ff; act_in = act_ff;
      ch_in = ch_ff; inside_in = inside_ff; tab_in = tab_ff;
      scx_in = scx_ff; scy_in = scy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in = rsp_cell_ff; rsp_col_in = rsp_col_ff; rsp_row_in = rsp_row_ff;
      wr_en = 1'b0; wr_addr = sweep_ff; wr_data = {8'd0, DEFAULT_FG, 24'd0};
      rd_addr = {RW'(req_pos_y), CW'(req_pos_x)};

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               act_in = req_action; ch_in = req_char_code; inside_in = in_inside;
               // Saturate the cursor into the current screen
               sx_in = (cx_ff > last_col) ? last_col : cx_ff;
               sy_in = (cy_ff > last_row) ? last_row : cy_ff;
               if (req_action == ACT_AT) begin
                  wx_in = CW'(req_pos_x); wy_in = RW'(req_pos_y);
               end else begin
                  wx_in = sx_in; wy_in = sy_in;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            rsp_cell_in = '0;
            if (act_ff == ACT_READ) begin
               // Read data of the address issued at acceptance
               rsp_cell_in = inside_ff ? rd_data : '0;
            end else if ((act_ff == ACT_PUT || (act_ff == ACT_AT && inside_ff))
                         && enabled_ff) begin
               if (esc_ff == 2'd1) begin
                  esc_in = (ch_ff == CH_LBR) ? 2'd2 : 2'd0;
               end else if (esc_ff == 2'd2) begin
                  if (ch_ff == CH_HOME) begin
                     wx_in = '0; wy_in = '0;
                  end
                  esc_in = 2'd0;
               end else if (ch_ff == 8'd0) begin
               end else if (ch_ff == CH_ESC) begin
                  esc_in = 2'd1;
               end else if (ch_ff == CH_LF) begin
                  wx_in = '0;
                  tab_in = '0;
                  if (adv_scroll) begin
                     scx_in = '0; scy_in = '0; state_in = ST_SCRD;
                  end else wy_in = wy_ff + RW'(1);
               end else if (ch_ff == CH_TAB) begin
                  tab_in = (tab_rem != 9'd0) ? tab_step : '0;
                  if (tab_rem != 9'd0) state_in = ST_TAB;
               end else begin
                  wr_en = 1'b1; wr_addr = {wy_ff, wx_ff};
                  wr_data = {ch_ff, text_fg_ff, text_bg_ff};
                  tab_in = TW'(1); state_in = ST_TAB;
               end
            end
         end
         ST_TAB: begin
            // One cursor step per cycle, paused while a wrap scrolls the screen
            tab_in = tab_ff - TW'(1);
            if (tab_ff == TW'(1)) state_in = ST_DONE;
            if (adv_wrap) begin
               wx_in = '0;
               if (adv_scroll) begin
                  scx_in = '0; scy_in = '0; state_in = ST_SCRD;
               end else wy_in = wy_ff + RW'(1);
            end else wx_in = wx_ff + CW'(1);
         end
         ST_SCRD: begin
            // Read the cell below, or fill the bottom row
            if (scy_ff == last_row) begin
               state_in = ST_SCBL;
            end else begin
               rd_addr = {RW'(scy_ff + RW'(1)), scx_ff};
               state_in = ST_SCWR;
            end
         end
         ST_SCWR: begin
            wr_en = 1'b1; wr_addr = {scy_ff, scx_ff}; wr_data = rd_data;
            state_in = ST_SCRD;
            if (scx_ff == last_col) begin
               scx_in = '0; scy_in = scy_ff + RW'(1);
            end else scx_in = scx_ff + CW'(1);
         end
         ST_SCBL: begin
            // Blank the bottom row, then resume the remaining tab steps or finish
            wr_en = 1'b1; wr_addr = {scy_ff, scx_ff};
            wr_data = {8'd0, blank_fg_ff, blank_bg_ff};
            scx_in = scx_ff + CW'(1);
            if (scx_ff == last_col) state_in = (tab_ff != '0) ? ST_TAB : ST_DONE;
         end
         ST_DONE: begin
            if (act_ff == ACT_PUT) begin
               cx_in = wx_ff; cy_in = wy_ff;
            end else begin
               cx_in = sx_ff; cy_in = sy_ff;
            end
            rsp_col_in = cx_in; rsp_row_in = cy_in;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; sweep_ff <= '0; cx_ff <= '0; cy_ff <= '0;
         esc_ff <= '0; rsp_valid_ff <= 1'b0; tab_ff <= '0;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in; cx_ff <= cx_in; cy_ff <= cy_in;
         esc_ff <= esc_in; rsp_valid_ff <= rsp_valid_in; tab_ff <= tab_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff <= wx_in; wy_ff <= wy_in; sx_ff <= sx_in; sy_ff <= sy_in;
      act_ff <= act_in; ch_ff <= ch_in; inside_ff <= inside_in;
      scx_ff <= scx_in; scy_ff <= scy_in;
      rsp_cell_ff <= rsp_cell_in; rsp_col_ff <= rsp_col_in; rsp_row_ff <= rsp_row_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff[55:48];
   assign rsp_cell_fg    = rsp_cell_ff[47:24];
   assign rsp_cell_bg    = rsp_cell_ff[23:0];
   assign rsp_cursor_col = 7'(rsp_col_ff);
   assign rsp_cursor_row = 6'(rsp_row_ff);

   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept, "accept while busy")
   `ASSERT_IMPLY(a_esc_range, clock, reset, 1'b1, esc_ff != 2'd3, "bad escape phase")
   `ASSERT_NEXT(a_done_resp, clock, reset, state_ff == ST_DONE, rsp_valid_ff, "missing result")
endmodule
`default_nettype wire

### sv/ttce_store.sv
// ----------------------------------------------------------------------------
// ttce_store
// Screen cell memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ttce_store #(
   parameter int AW = 13
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire ttce_pkg::cell_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output ttce_pkg::cell_type      rd_data
);
   import ttce_pkg::*;

   cell_type mem [2**AW];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### sim/tb_text_terminal_cursor_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_terminal_cursor_engine_top
// Self-checking bench for the character terminal engine. A scoreboard class
// keeps its own screen store, cursor and escape parser, predicts the response
// word for every accepted request and compares it field by field. Phases vary
// the screen size (clamped extremes included), colors and enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_terminal_cursor_engine_top;
   import ttce_pkg::*;

   typedef struct packed {
      logic [7:0]  ch;
      logic [23:0] fg;
      logic [23:0] bg;
      logic [6:0]  col;
      logic [5:0]  row;
   } rsp_word_type;

   class term_scoreboard;
      typedef enum int {ESC_NONE, ESC_WANT_BRACKET, ESC_WANT_CMD} esc_state_type;

      cell_type      screen [DEF_MAX_COLUMNS * DEF_MAX_ROWS];
      int            cur_x, cur_y;
      esc_state_type esc;
      logic [7:0]    cols_reg;
      logic [6:0]    rows_reg;
      logic [23:0]   text_fg, text_bg, blank_fg, blank_bg;
      logic          enabled;
      rsp_word_type  due_q[$];
      int            mismatches;

      function new();
         foreach (screen[i]) screen[i] = {8'd0, DEFAULT_FG, 24'd0};
         cur_x = 0;
         cur_y = 0;
         esc = ESC_NONE;
         cols_reg = 8'd80;
         rows_reg = 7'd25;
         text_fg = DEFAULT_FG;
         text_bg = 24'd0;
         blank_fg = DEFAULT_FG;
         blank_bg = 24'd0;
         enabled = 1'b1;
         mismatches = 0;
      endfunction

      function int n_cols();
         if (cols_reg == 0) return 1;
         if (cols_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
         return cols_reg;
      endfunction

      function int n_rows();
         if (rows_reg == 0) return 1;
         if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
         return rows_reg;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] d);
         case (idx)
            REG_COLS:     cols_reg = d[7:0];
            REG_ROWS:     rows_reg = d[6:0];
            REG_TEXT_FG:  text_fg = d;
            REG_TEXT_BG:  text_bg = d;
            REG_BLANK_FG: blank_fg = d;
            REG_BLANK_BG: blank_bg = d;
            REG_ENABLED:  enabled = d[0];
            default: ;
         endcase
      endfunction

      // shift every visible row up by one and blank the bottom row
      function void scroll_up();
         int c, r;
         c = n_cols();
         r = n_rows();
         for (int y = 0; y + 1 < r; y++)
            for (int x = 0; x < c; x++)
               screen[y * DEF_MAX_COLUMNS + x] = screen[(y + 1) * DEF_MAX_COLUMNS + x];
         for (int x = 0; x < c; x++)
            screen[(r - 1) * DEF_MAX_COLUMNS + x] = {8'd0, blank_fg, blank_bg};
      endfunction

      function void line_feed();
         if (cur_y >= n_rows() - 1) scroll_up();
         else cur_y++;
         cur_x = 0;
      endfunction

      function void step_right();
         if (cur_x >= n_cols() - 1) line_feed();
         else cur_x++;
      endfunction

      function void tab_over();
         int n;
         n = DEF_TAB_WIDTH - ((cur_x + 1) % DEF_TAB_WIDTH);
         if (n == DEF_TAB_WIDTH) return;
         for (int i = 0; i < n; i++) step_right();
      endfunction

      function void feed(logic [7:0] c);
         if (esc == ESC_WANT_BRACKET) begin
            esc = (c == CH_LBR) ? ESC_WANT_CMD : ESC_NONE;
            return;
         end
         if (esc == ESC_WANT_CMD) begin
            if (c == CH_HOME) begin
               cur_x = 0;
               cur_y = 0;
            end
            esc = ESC_NONE;
            return;
         end
         if (c == 8'd0) return;
         if (c == CH_ESC) esc = ESC_WANT_BRACKET;
         else if (c == CH_LF) line_feed();
         else if (c == CH_TAB) tab_over();
         else begin
            screen[cur_y * DEF_MAX_COLUMNS + cur_x] = {c, text_fg, text_bg};
            step_right();
         end
      endfunction

      // predict the response word of one accepted request
      function void note_request(logic [1:0] act, logic [7:0] c, logic [6:0] px,
                                 logic [5:0] py);
         rsp_word_type w;
         cell_type     rd;
         bit           on_screen;
         int           sx, sy;
         rd = '0;
         on_screen = (px < n_cols()) && (py < n_rows());
         if (cur_x >= n_cols()) cur_x = n_cols() - 1;
         if (cur_y >= n_rows()) cur_y = n_rows() - 1;
         if (act == ACT_PUT) begin
            if (enabled) feed(c);
         end else if (act == ACT_AT) begin
            if (enabled && on_screen) begin
               sx = cur_x;
               sy = cur_y;
               cur_x = px;
               cur_y = py;
               feed(c);
               cur_x = sx;
               cur_y = sy;
            end
         end else if (act == ACT_READ) begin
            if (on_screen) rd = screen[py * DEF_MAX_COLUMNS + px];
         end
         w.ch = rd[55:48];
         w.fg = rd[47:24];
         w.bg = rd[23:0];
         w.col = cur_x[6:0];
         w.row = cur_y[5:0];
         due_q.push_back(w);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type w;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response word with nothing expected: ch=%h col=%0d row=%0d",
                        got.ch, got.col, got.row);
            return;
         end
         w = due_q.pop_front();
         if (w != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: exp ch=%h fg=%h bg=%h col=%0d row=%0d, ",
                         "got ch=%h fg=%h bg=%h col=%0d row=%0d"},
                        w.ch, w.fg, w.bg, w.col, w.row,
                        got.ch, got.fg, got.bg, got.col, got.row);
         end
      endfunction
   endclass

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 100000;
   localparam int HOLD_CYCLES = 300;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_action;
   logic [7:0]  req_char_code;
   logic [6:0]  req_pos_x;
   logic [5:0]  req_pos_y;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_cell_char;
   logic [23:0] rsp_cell_fg, rsp_cell_bg;
   logic [6:0]  rsp_cursor_col;
   logic [5:0]  rsp_cursor_row;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   term_scoreboard sb;
   logic        quiet;
   logic        hold_go;
   logic        hold_done = 1'b0;
   int          hold_cnt = 0;
   int          idle_cycles = 0;
   logic [7:0]  esc_q[$];

   text_terminal_cursor_engine_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: check accepted words, stall at random, one long hold-off
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.ch = rsp_cell_char;
         got.fg = rsp_cell_fg;
         got.bg = rsp_cell_bg;
         got.col = rsp_cursor_col;
         got.row = rsp_cursor_row;
         sb.check_response(got);
      end
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cnt <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 13);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("tb_text_terminal_cursor_engine_top: errors");
            $finish;
         end
      end
   end

   task automatic send_word(logic [1:0] act, logic [7:0] c, logic [6:0] px,
                            logic [5:0] py);
      if (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_char_code <= c;
      req_pos_x <= px;
      req_pos_y <= py;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_request(act, c, px, py);
   endtask

   // drain outstanding words before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(logic [7:0] cols, logic [6:0] rows, logic [23:0] tfg,
                             logic [23:0] tbg, logic [23:0] bfg, logic [23:0] bbg,
                             logic en);
      logic [23:0] vals [7];
      vals[REG_COLS] = {16'd0, cols};
      vals[REG_ROWS] = {17'd0, rows};
      vals[REG_TEXT_FG] = tfg;
      vals[REG_TEXT_BG] = tbg;
      vals[REG_BLANK_FG] = bfg;
      vals[REG_BLANK_BG] = bbg;
      vals[REG_ENABLED] = {23'd0, en};
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= vals[i];
         forever begin
            @(posedge clock);
            if (csr_ready) break;
         end
         sb.write_reg(i[2:0], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // random word: mostly printable text, line and tab control, escape runs
   task automatic random_word();
      logic [1:0] act;
      logic [7:0] c;
      logic [6:0] px;
      logic [5:0] py;
      int         k;
      k = $urandom_range(0, 99);
      act = (k < 50) ? ACT_PUT : (k < 70) ? ACT_AT : (k < 93) ? ACT_READ : ACT_UNUSED;
      if (esc_q.size() != 0) begin
         act = ACT_PUT;
         c = esc_q.pop_front();
      end else begin
         k = $urandom_range(0, 99);
         if (k < 55) c = 8'($urandom_range(32, 126));
         else if (k < 65) c = CH_LF;
         else if (k < 73) c = CH_TAB;
         else if (k < 78) c = 8'd0;
         else if (k < 86) begin
            c = CH_ESC;
            if ($urandom_range(0, 9) < 7) begin
               esc_q.push_back(CH_LBR);
               esc_q.push_back(($urandom_range(0, 9) < 6) ? CH_HOME
                                                          : 8'($urandom_range(0, 255)));
            end else begin
               esc_q.push_back(8'($urandom_range(0, 255)));
            end
         end else c = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 85) begin
         px = 7'($urandom_range(0, sb.n_cols() - 1));
         py = 6'($urandom_range(0, sb.n_rows() - 1));
      end else begin
         px = 7'($urandom_range(0, 127));
         py = 6'($urandom_range(0, 63));
      end
      send_word(act, c, px, py);
   endtask

   task automatic run_phase(logic [7:0] cols, logic [6:0] rows, int count, logic en,
                            int colors);
      logic [23:0] tfg, tbg, bfg, bbg;
      tfg = 24'($urandom());
      tbg = 24'($urandom());
      bfg = 24'($urandom());
      bbg = 24'($urandom());
      if (colors == 1) {tfg, tbg, bfg, bbg} = '1;
      if (colors == 2) {tfg, tbg, bfg, bbg} = '0;
      settle();
      write_regs(cols, rows, tfg, tbg, bfg, bbg, en);
      esc_q.delete();
      for (int i = 0; i < count; i++) random_word();
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      hold_go = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_PUT;
      req_char_code <= 8'd0;
      req_pos_x <= 7'd0;
      req_pos_y <= 6'd0;
      csr_valid <= 1'b0;
      csr_index <= REG_COLS;
      csr_data <= 24'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed checks at the reset settings
      send_word(ACT_READ, 8'd0, 7'd0, 6'd0);
      send_word(ACT_PUT, "A", 7'd0, 6'd0);
      send_word(ACT_PUT, 8'hFF, 7'd0, 6'd0);
      send_word(ACT_PUT, 8'd0, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_TAB, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_TAB, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_LF, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_ESC, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_LBR, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_HOME, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_ESC, 7'd0, 6'd0);
      send_word(ACT_PUT, "x", 7'd0, 6'd0);
      send_word(ACT_PUT, CH_ESC, 7'd0, 6'd0);
      send_word(ACT_PUT, CH_LBR, 7'd0, 6'd0);
      send_word(ACT_PUT, "Z", 7'd0, 6'd0);
      send_word(ACT_AT, "Z", 7'd79, 6'd24);
      send_word(ACT_AT, "Q", 7'd80, 6'd0);
      send_word(ACT_AT, CH_ESC, 7'd127, 6'd63);
      send_word(ACT_AT, CH_LF, 7'd5, 6'd24);
      send_word(ACT_READ, 8'd0, 7'd79, 6'd23);
      send_word(ACT_READ, 8'd0, 7'd0, 6'd0);
      send_word(ACT_READ, 8'd0, 7'd127, 6'd63);
      send_word(ACT_UNUSED, 8'hFF, 7'd3, 6'd3);
      send_word(ACT_AT, CH_TAB, 7'd78, 6'd3);

      // size, color and enable phases, extremes first
      run_phase(8'd1, 7'd1, 40, 1'b1, 1);
      run_phase(8'd0, 7'd0, 20, 1'b1, 2);
      run_phase(8'd128, 7'd64, 25, 1'b1, 0);
      run_phase(8'd255, 7'd127, 10, 1'b1, 0);
      run_phase(8'd80, 7'd25, 60, 1'b1, 0);
      quiet = 1'b1;
      run_phase(8'd8, 7'd4, 80, 1'b1, 0);
      quiet = 1'b0;
      run_phase(8'd12, 7'd3, 30, 1'b0, 0);
      run_phase(8'd9, 7'd6, 40, 1'b1, 0);
      hold_go = 1'b1;
      for (int i = 0; i < 40; i++) random_word();
      for (int p = 0; p < 4; p++)
         run_phase(8'($urandom_range(1, 20)), 7'($urandom_range(1, 8)), 50, 1'b1, 0);

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_text_terminal_cursor_engine_top: clean");
      end else begin
         $display("tb_text_terminal_cursor_engine_top: errors");
      end
      $finish;
   end
endmodule

`default_nettype wire
